// ----- design/ktm_pkg.sv -----
// ----------------------------------------------------------------------------
// ktm_pkg: shared types and constants of the keyword trie matcher
// Table sizes, field widths, function and status codes, and the record
// structs that pass between the sequencer, the node table and the output register.
// ----------------------------------------------------------------------------
package ktm_pkg;

    localparam int NODES    = 256;
    localparam int KEYWORDS = 64;
    localparam int POS_W    = 32;

    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = NODE_W + 1;
    localparam int WORD_W = 7;
    localparam int OUT_POS_W = 32;

    // input functions
    localparam logic [1:0] FN_KEY_BYTE  = 2'd0;
    localparam logic [1:0] FN_KEY_END   = 2'd1;
    localparam logic [1:0] FN_TEXT_BYTE = 2'd2;
    localparam logic [1:0] FN_TEXT_NEW  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUP       = 2'd1;
    localparam logic [1:0] ST_NODE_FULL = 2'd2;
    localparam logic [1:0] ST_WORD_FULL = 2'd3;

    typedef struct packed {
        logic              we_rec;
        logic              we_fb;
        logic              we_word;
        logic [NODE_W-1:0] addr;
        logic [7:0]        chr;
        logic [NODE_W-1:0] up;
        logic [7:0]        level;
        logic [NODE_W-1:0] fb;
        logic [WORD_W-1:0] word;
    } ram_wr_t;

    typedef struct packed {
        logic [7:0]        chr;
        logic [NODE_W-1:0] up;
        logic [7:0]        level;
        logic [NODE_W-1:0] fb;
        logic [WORD_W-1:0] word;
    } ram_rd_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 found;
        logic [WORD_W-1:0]    number;
        logic [OUT_POS_W-1:0] start;
    } res_t;

endpackage

// ----- design/ktm_node_ram.sv -----
// ----------------------------------------------------------------------------
// ktm_node_ram: trie node table
// One write port with per-field enables and one registered read port.
// The root entry reads as level zero, fallback root and no keyword.
// ----------------------------------------------------------------------------
module ktm_node_ram
    import ktm_pkg::*;
(
    input  logic              aclk,
    input  ram_wr_t           wr,
    input  logic              rd_en,
    input  logic [NODE_W-1:0] rd_addr,
    output ram_rd_t           rd
);

    logic [7:0]        chr_mem  [NODES];
    logic [NODE_W-1:0] up_mem   [NODES];
    logic [7:0]        lvl_mem  [NODES];
    logic [NODE_W-1:0] fb_mem   [NODES];
    logic [WORD_W-1:0] word_mem [NODES];

    ram_rd_t rd_reg;
    logic    root_reg;

    always_ff @(posedge aclk) begin
        if (wr.we_rec) begin
            chr_mem[wr.addr] <= wr.chr;
            up_mem[wr.addr]  <= wr.up;
            lvl_mem[wr.addr] <= wr.level;
        end
        if (wr.we_fb) begin
            fb_mem[wr.addr] <= wr.fb;
        end
        if (wr.we_word) begin
            word_mem[wr.addr] <= wr.word;
        end
        if (rd_en) begin
            rd_reg.chr   <= chr_mem[rd_addr];
            rd_reg.up    <= up_mem[rd_addr];
            rd_reg.level <= lvl_mem[rd_addr];
            rd_reg.fb    <= fb_mem[rd_addr];
            rd_reg.word  <= word_mem[rd_addr];
            root_reg     <= (rd_addr == '0);
        end
    end

    always_comb begin
        rd = rd_reg;
        if (root_reg) begin
            rd.level = '0;
            rd.fb    = '0;
            rd.word  = '0;
        end
    end

endmodule

// ----- design/ktm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ktm_ctrl: matcher sequencer
// Runs keyword insertion, failure-link rebuild and text scanning as steps
// around one shared child-search compare that walks the node table.
// ----------------------------------------------------------------------------
module ktm_ctrl
    import ktm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [1:0]        in_func,
    input  logic [7:0]        in_char,
    output logic              in_ready,
    input  logic              out_free,
    output logic              done,
    output res_t              result,
    output logic              rd_en,
    output logic [NODE_W-1:0] rd_addr,
    input  ram_rd_t           rd,
    output ram_wr_t           wr
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_K_LVL  = 4'd1;
    localparam logic [3:0] S_K_CHK  = 4'd2;
    localparam logic [3:0] S_E_WORD = 4'd3;
    localparam logic [3:0] S_SRCH   = 4'd4;
    localparam logic [3:0] S_T_RES  = 4'd5;
    localparam logic [3:0] S_T_FB   = 4'd6;
    localparam logic [3:0] S_T_OUT  = 4'd7;
    localparam logic [3:0] S_RB_I   = 4'd8;
    localparam logic [3:0] S_RB_REC = 4'd9;
    localparam logic [3:0] S_RB_FB  = 4'd10;
    localparam logic [3:0] S_RB_CHK = 4'd11;

    logic [3:0]        state_reg, state_next, ret_reg, ret_next;
    logic [7:0]        ch_reg, ch_next;
    logic [NODE_W-1:0] insert_reg, insert_next, scan_reg, scan_next;
    logic [NODE_W-1:0] cur_reg, cur_next, srch_p_reg, srch_p_next;
    logic [7:0]        srch_b_reg, srch_b_next;
    logic [NODE_W-1:0] idx_reg, idx_next, pidx_reg, pidx_next;
    logic              hit_reg, hit_next, pend_reg, pend_next;
    logic [CNT_W-1:0]  i_reg, i_next, nodes_reg, nodes_next;
    logic [WORD_W-1:0] words_reg, words_next;
    logic              bad_reg, bad_next;
    logic [POS_W-1:0]  text_reg, text_next;
    logic [7:0]        max_lvl_reg, max_lvl_next, lvl_reg, lvl_next;
    logic [7:0]        rb_lv_reg, rb_lv_next, rb_byte_reg, rb_byte_next;
    logic [CNT_W-1:0]  rb_i_reg, rb_i_next;

    logic              match;
    logic [NODE_W-1:0] new_node, scan_new;
    logic [7:0]        new_lvl;
    logic [POS_W-1:0]  start_full;

    assign in_ready   = (state_reg == S_IDLE) && out_free;
    assign match      = pend_reg && (rd.up == srch_p_reg) && (rd.chr == srch_b_reg);
    assign new_node   = nodes_reg[NODE_W-1:0];
    assign new_lvl    = lvl_reg + 8'd1;
    assign scan_new   = hit_reg ? idx_reg : '0;
    assign start_full = text_reg - POS_W'(rd.level) + POS_W'(1);

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        ch_next      = ch_reg;
        insert_next  = insert_reg;
        scan_next    = scan_reg;
        cur_next     = cur_reg;
        srch_p_next  = srch_p_reg;
        srch_b_next  = srch_b_reg;
        idx_next     = idx_reg;
        pidx_next    = pidx_reg;
        hit_next     = hit_reg;
        pend_next    = pend_reg;
        i_next       = i_reg;
        nodes_next   = nodes_reg;
        words_next   = words_reg;
        bad_next     = bad_reg;
        text_next    = text_reg;
        max_lvl_next = max_lvl_reg;
        lvl_next     = lvl_reg;
        rb_lv_next   = rb_lv_reg;
        rb_byte_next = rb_byte_reg;
        rb_i_next    = rb_i_reg;
        done         = 1'b0;
        result       = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr           = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    ch_next = in_char;
                    unique case (in_func)
                        FN_KEY_BYTE: begin
                            rd_en      = 1'b1;
                            rd_addr    = insert_reg;
                            state_next = S_K_LVL;
                        end
                        FN_KEY_END: begin
                            if (bad_reg) begin
                                done          = 1'b1;
                                result.status = ST_NODE_FULL;
                                insert_next   = '0;
                                bad_next      = 1'b0;
                            end else if (insert_reg == '0) begin
                                done = 1'b1;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = insert_reg;
                                state_next = S_E_WORD;
                            end
                        end
                        FN_TEXT_BYTE: begin
                            cur_next    = scan_reg;
                            srch_p_next = scan_reg;
                            srch_b_next = in_char;
                            ret_next    = S_T_RES;
                            i_next      = CNT_W'(1);
                            pend_next   = 1'b0;
                            state_next  = S_SRCH;
                        end
                        default: begin
                            scan_next = '0;
                            text_next = '0;
                            done      = 1'b1;
                        end
                    endcase
                end
            end
            // shared child search: one table entry read per cycle, each compared in the cycle after its read
            S_SRCH: begin
                if (match) begin
                    hit_next   = 1'b1;
                    idx_next   = pidx_reg;
                    state_next = ret_reg;
                end else if (i_reg >= nodes_reg) begin
                    hit_next   = 1'b0;
                    state_next = ret_reg;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = i_reg[NODE_W-1:0];
                    pend_next = 1'b1;
                    pidx_next = i_reg[NODE_W-1:0];
                    i_next    = i_reg + CNT_W'(1);
                end
            end
            S_K_LVL: begin
                lvl_next    = rd.level;
                srch_p_next = insert_reg;
                srch_b_next = ch_reg;
                ret_next    = S_K_CHK;
                i_next      = CNT_W'(1);
                pend_next   = 1'b0;
                state_next  = S_SRCH;
            end
            S_K_CHK: begin
                done       = 1'b1;
                state_next = S_IDLE;
                if (hit_reg) begin
                    insert_next = idx_reg;
                end else if (nodes_reg < CNT_W'(NODES)) begin
                    wr.we_rec   = 1'b1;
                    wr.we_fb    = 1'b1;
                    wr.we_word  = 1'b1;
                    wr.addr     = new_node;
                    wr.chr      = ch_reg;
                    wr.up       = insert_reg;
                    wr.level    = new_lvl;
                    nodes_next  = nodes_reg + CNT_W'(1);
                    insert_next = new_node;
                    if (new_lvl > max_lvl_reg) begin
                        max_lvl_next = new_lvl;
                    end
                end else begin
                    bad_next      = 1'b1;
                    result.status = ST_NODE_FULL;
                end
            end
            S_E_WORD: begin
                insert_next = '0;
                if (rd.word != '0) begin
                    done          = 1'b1;
                    result.status = ST_DUP;
                    state_next    = S_IDLE;
                end else if (words_reg >= WORD_W'(KEYWORDS)) begin
                    done          = 1'b1;
                    result.status = ST_WORD_FULL;
                    state_next    = S_IDLE;
                end else begin
                    wr.we_word = 1'b1;
                    wr.addr    = insert_reg;
                    wr.word    = words_reg + WORD_W'(1);
                    words_next = words_reg + WORD_W'(1);
                    rb_lv_next = 8'd1;
                    rb_i_next  = CNT_W'(1);
                    state_next = S_RB_I;
                end
            end
            // rebuild: sweep the table once per depth, shallow first
            S_RB_I: begin
                if (rb_i_reg < nodes_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = rb_i_reg[NODE_W-1:0];
                    state_next = S_RB_REC;
                end else if (rb_lv_reg >= max_lvl_reg) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    rb_lv_next = rb_lv_reg + 8'd1;
                    rb_i_next  = CNT_W'(1);
                end
            end
            S_RB_REC: begin
                if (rd.level != rb_lv_reg) begin
                    rb_i_next  = rb_i_reg + CNT_W'(1);
                    state_next = S_RB_I;
                end else if (rd.up == '0) begin
                    wr.we_fb   = 1'b1;
                    wr.addr    = rb_i_reg[NODE_W-1:0];
                    rb_i_next  = rb_i_reg + CNT_W'(1);
                    state_next = S_RB_I;
                end else begin
                    rb_byte_next = rd.chr;
                    rd_en        = 1'b1;
                    rd_addr      = rd.up;
                    state_next   = S_RB_FB;
                end
            end
            S_RB_FB: begin
                cur_next    = rd.fb;
                srch_p_next = rd.fb;
                srch_b_next = rb_byte_reg;
                ret_next    = S_RB_CHK;
                i_next      = CNT_W'(1);
                pend_next   = 1'b0;
                state_next  = S_SRCH;
            end
            S_RB_CHK: begin
                if (!hit_reg && cur_reg != '0) begin
                    rd_en      = 1'b1;
                    rd_addr    = cur_reg;
                    state_next = S_RB_FB;
                end else begin
                    wr.we_fb = 1'b1;
                    wr.addr  = rb_i_reg[NODE_W-1:0];
                    if (hit_reg && idx_reg != rb_i_reg[NODE_W-1:0]) begin
                        wr.fb = idx_reg;
                    end
                    rb_i_next  = rb_i_reg + CNT_W'(1);
                    state_next = S_RB_I;
                end
            end
            S_T_RES: begin
                if (!hit_reg && cur_reg != '0) begin
                    rd_en      = 1'b1;
                    rd_addr    = cur_reg;
                    state_next = S_T_FB;
                end else begin
                    scan_next  = scan_new;
                    rd_en      = 1'b1;
                    rd_addr    = scan_new;
                    state_next = S_T_OUT;
                end
            end
            S_T_FB: begin
                cur_next    = rd.fb;
                srch_p_next = rd.fb;
                srch_b_next = ch_reg;
                ret_next    = S_T_RES;
                i_next      = CNT_W'(1);
                pend_next   = 1'b0;
                state_next  = S_SRCH;
            end
            S_T_OUT: begin
                done       = 1'b1;
                state_next = S_IDLE;
                text_next  = text_reg + POS_W'(1);
                if (rd.word != '0) begin
                    result.found  = 1'b1;
                    result.number = rd.word;
                    result.start  = start_full[OUT_POS_W-1:0];
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            insert_reg  <= '0;
            scan_reg    <= '0;
            nodes_reg   <= CNT_W'(1);
            words_reg   <= '0;
            bad_reg     <= 1'b0;
            text_reg    <= '0;
            max_lvl_reg <= '0;
        end else begin
            state_reg   <= state_next;
            insert_reg  <= insert_next;
            scan_reg    <= scan_next;
            nodes_reg   <= nodes_next;
            words_reg   <= words_next;
            bad_reg     <= bad_next;
            text_reg    <= text_next;
            max_lvl_reg <= max_lvl_next;
        end
        ret_reg     <= ret_next;
        ch_reg      <= ch_next;
        cur_reg     <= cur_next;
        srch_p_reg  <= srch_p_next;
        srch_b_reg  <= srch_b_next;
        idx_reg     <= idx_next;
        pidx_reg    <= pidx_next;
        hit_reg     <= hit_next;
        pend_reg    <= pend_next;
        i_reg       <= i_next;
        lvl_reg     <= lvl_next;
        rb_lv_reg   <= rb_lv_next;
        rb_byte_reg <= rb_byte_next;
        rb_i_reg    <= rb_i_next;
    end

    a_nodes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (nodes_reg != '0) && (nodes_reg <= CNT_W'(NODES)))
        else $error("node count out of range");

    a_insert_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(insert_reg) < nodes_reg)
        else $error("insert node beyond table fill");

    a_scan_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(scan_reg) < nodes_reg)
        else $error("scan node beyond table fill");

    a_done_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> out_free)
        else $error("result produced while output register is occupied");

endmodule

// ----- design/keyword_trie_multi_match.sv -----
// ----------------------------------------------------------------------------
// keyword_trie_multi_match: multi-keyword string matcher with failure links
// Loads keywords into a trie node table and scans text against all of them.
// ----------------------------------------------------------------------------
// Usage:
//   Send one beat per command on the slave side: s_tuser selects the function
//   (keyword byte, end keyword, text byte, start new text) and s_tdata carries
//   the byte. Every beat returns exactly one result beat on the master side:
//   m_tuser gives status and the match flag, m_tdata the keyword number and
//   the start position of the match.
//   One beat is worked on at a time; s_tready stays low until its result is
//   loaded into the output register, and m_tvalid rises the cycle after.
//   An end keyword completes without a table read when the keyword is empty
//   or after a node-table overflow; one that adds a new keyword triggers a
//   link rebuild that sweeps the table once per trie depth and walks each
//   failure chain, with a child search per step. A keyword byte runs one
//   child search, a text byte one plus one per failure step taken. The
//   child search walks the node table one entry per cycle through its
//   single read port.
//   Reset empties the trie to the root alone, clears keyword count and text
//   position. When the receiver stalls, the result beat holds in the output
//   register and the next beat is not taken until it leaves.
// ----------------------------------------------------------------------------
module keyword_trie_multi_match
    import ktm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [6:0] keyword_number, [38:7] start_position, zero pad
    output logic [2:0]  m_tuser    // [1:0] status, [2] match_found
);

    logic              out_valid_reg;
    res_t              out_reg;
    logic              out_free;
    logic              done;
    res_t              result;
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    ram_rd_t           rd;
    ram_wr_t           wr;

    // output register frees when empty or when the current beat is taken
    assign out_free = !out_valid_reg || m_tready;

    ktm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_char  (s_tdata),
        .in_ready (s_tready),
        .out_free (out_free),
        .done     (done),
        .result   (result),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd       (rd),
        .wr       (wr)
    );

    ktm_node_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd      (rd)
    );

    // hold the result beat until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (done) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.found, out_reg.status};
    assign m_tdata  = {1'b0, out_reg.start, out_reg.number};

endmodule
